>>> hw/rtl/sgs_pkg.sv
// ----------------------------------------------------------------------------
// sgs_pkg
// Shared constants, codes and control structs of the scatter-gather segmenter.
// ----------------------------------------------------------------------------
package sgs_pkg;

  localparam int MaxDescs = 16;
  localparam int IdxW     = $clog2(MaxDescs);
  localparam int CntW     = $clog2(MaxDescs + 1);

  localparam int AddrW = 64;
  localparam int LenW  = 32;
  localparam int FlagW = 16;
  localparam int SizeW = 36;
  localparam int StW   = 3;

  localparam int WriteOnlyBit = 1;

  localparam logic [1:0] OpAppend = 2'd0;
  localparam logic [1:0] OpClear  = 2'd1;
  localparam logic [1:0] OpCopy   = 2'd2;
  localparam logic [1:0] OpQuery  = 2'd3;

  localparam logic [StW-1:0] StOk       = 3'd0;
  localparam logic [StW-1:0] StExceeds  = 3'd1;
  localparam logic [StW-1:0] StNotFound = 3'd2;
  localparam logic [StW-1:0] StPerm     = 3'd3;
  localparam logic [StW-1:0] StFull     = 3'd4;

  localparam logic [2:0] EmNone   = 3'd0;
  localparam logic [2:0] EmAppend = 3'd1;
  localparam logic [2:0] EmPlain  = 3'd2;
  localparam logic [2:0] EmQuery  = 3'd3;
  localparam logic [2:0] EmSeg    = 3'd4;
  localparam logic [2:0] EmPerm   = 3'd5;

  typedef struct packed {
    logic           latch;
    logic           append;
    logic           clear;
    logic           walk_reset;
    logic           seek_step;
    logic           seg_begin;
    logic           query_step;
    logic [2:0]     emit;
    logic [StW-1:0] emit_status;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       size_zero;
    logic       exceeds;
    logic       off_zero;
    logic       count_zero;
    logic       at_end;
    logic       seek_hit;
    logic       perm_fail;
    logic       seg_last;
    logic       query_stop;
    logic       out_free;
  } stat_t;

endpackage

>>> hw/rtl/sgs_req_if.sv
// ----------------------------------------------------------------------------
// sgs_req_if
// Request channel: one beat carries one operation.
// ----------------------------------------------------------------------------
interface sgs_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  opcode;
  logic [sgs_pkg::AddrW-1:0]   desc_address;
  logic [sgs_pkg::LenW-1:0]    desc_length;
  logic [sgs_pkg::FlagW-1:0]   desc_flags;
  logic [sgs_pkg::SizeW-1:0]   copy_size;
  logic [sgs_pkg::SizeW-1:0]   copy_offset;
  logic                        copy_into_chain;

  modport source (output valid, opcode, desc_address, desc_length, desc_flags,
                  copy_size, copy_offset, copy_into_chain, input ready);
  modport sink (input valid, opcode, desc_address, desc_length, desc_flags,
                copy_size, copy_offset, copy_into_chain, output ready);
endinterface

>>> hw/rtl/sgs_rsp_if.sv
// ----------------------------------------------------------------------------
// sgs_rsp_if
// Result channel: one beat carries one segment or one status result.
// ----------------------------------------------------------------------------
interface sgs_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [sgs_pkg::StW-1:0]     status;
  logic [sgs_pkg::AddrW-1:0]   seg_address;
  logic [sgs_pkg::LenW-1:0]    seg_length;
  logic [sgs_pkg::IdxW-1:0]    seg_index;
  logic [sgs_pkg::SizeW-1:0]   linear_offset;
  logic [sgs_pkg::SizeW-1:0]   bytes_done;
  logic [sgs_pkg::LenW-1:0]    written_bound;
  logic                        last;

  modport source (output valid, status, seg_address, seg_length, seg_index,
                  linear_offset, bytes_done, written_bound, last, input ready);
  modport sink (input valid, status, seg_address, seg_length, seg_index,
                linear_offset, bytes_done, written_bound, last, output ready);
endinterface

>>> hw/rtl/sgs_datapath.sv
// ----------------------------------------------------------------------------
// sgs_datapath
// Descriptor store, walk counters, request latch and result register.
// ----------------------------------------------------------------------------
module sgs_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  sgs_pkg::cmd_t       cmd,
  output sgs_pkg::stat_t      stat,
  sgs_req_if.sink             req,
  sgs_rsp_if.source           rsp
);

  logic [sgs_pkg::AddrW-1:0] entry_address  [sgs_pkg::MaxDescs];
  logic [sgs_pkg::LenW-1:0]  entry_length   [sgs_pkg::MaxDescs];
  logic [sgs_pkg::FlagW-1:0] entry_flags    [sgs_pkg::MaxDescs];
  logic [sgs_pkg::LenW-1:0]  written_prefix [sgs_pkg::MaxDescs];

  logic [sgs_pkg::CntW-1:0]  chain_count;
  logic [sgs_pkg::SizeW-1:0] total_bytes;
  logic                      device_side;

  logic [1:0]                op;
  logic [sgs_pkg::AddrW-1:0] r_addr;
  logic [sgs_pkg::LenW-1:0]  r_len;
  logic [sgs_pkg::FlagW-1:0] r_flags;
  logic [sgs_pkg::SizeW-1:0] r_size;
  logic [sgs_pkg::SizeW-1:0] r_off;
  logic                      r_into;

  logic [sgs_pkg::CntW-1:0]  idx;
  logic [sgs_pkg::SizeW-1:0] cur;
  logic [sgs_pkg::LenW-1:0]  loc;
  logic [sgs_pkg::SizeW-1:0] rem;
  logic [sgs_pkg::SizeW-1:0] done;
  logic [sgs_pkg::LenW-1:0]  lb;

  logic                      out_valid;
  logic [sgs_pkg::StW-1:0]   o_status;
  logic [sgs_pkg::AddrW-1:0] o_addr;
  logic [sgs_pkg::LenW-1:0]  o_len;
  logic [sgs_pkg::IdxW-1:0]  o_idx;
  logic [sgs_pkg::SizeW-1:0] o_lin;
  logic [sgs_pkg::SizeW-1:0] o_done;
  logic [sgs_pkg::LenW-1:0]  o_wb;
  logic                      o_last;

  logic [sgs_pkg::StW-1:0]   o_status_next;
  logic [sgs_pkg::AddrW-1:0] o_addr_next;
  logic [sgs_pkg::LenW-1:0]  o_len_next;
  logic [sgs_pkg::IdxW-1:0]  o_idx_next;
  logic [sgs_pkg::SizeW-1:0] o_lin_next;
  logic [sgs_pkg::SizeW-1:0] o_done_next;
  logic [sgs_pkg::LenW-1:0]  o_wb_next;
  logic                      o_last_next;

  logic [sgs_pkg::IdxW-1:0]  ix;
  logic [sgs_pkg::LenW-1:0]  cur_len;
  logic [sgs_pkg::LenW-1:0]  cur_pre;
  logic                      cur_wo;
  logic [sgs_pkg::LenW-1:0]  avail;
  logic [sgs_pkg::LenW-1:0]  n;
  logic [sgs_pkg::SizeW:0]   cur_end;
  logic [sgs_pkg::SizeW:0]   req_end;
  logic [sgs_pkg::LenW:0]    wr_end;
  logic [sgs_pkg::LenW:0]    lb_sum;

  assign ix      = idx[sgs_pkg::IdxW-1:0];
  assign cur_len = entry_length[ix];
  assign cur_pre = written_prefix[ix];
  assign cur_wo  = entry_flags[ix][sgs_pkg::WriteOnlyBit];
  assign avail   = cur_len - loc;
  assign n       = ({{(sgs_pkg::SizeW-sgs_pkg::LenW){1'b0}}, avail} < rem)
                   ? avail : rem[sgs_pkg::LenW-1:0];
  assign cur_end = {1'b0, cur} + {{(sgs_pkg::SizeW-sgs_pkg::LenW+1){1'b0}}, cur_len};
  assign req_end = {1'b0, r_off} + {1'b0, r_size};
  assign wr_end  = {1'b0, loc} + {1'b0, n};
  assign lb_sum  = {1'b0, lb} + {1'b0, cur_pre};

  always_comb begin
    stat.op         = op;
    stat.full       = (chain_count == sgs_pkg::CntW'(sgs_pkg::MaxDescs));
    stat.size_zero  = (r_size == '0);
    stat.exceeds    = (req_end > {1'b0, total_bytes});
    stat.off_zero   = (r_off == '0);
    stat.count_zero = (chain_count == '0);
    stat.at_end     = (idx == chain_count);
    stat.seek_hit   = (cur_end > {1'b0, r_off});
    stat.perm_fail  = r_into && device_side && !cur_wo;
    stat.seg_last   = (rem == {{(sgs_pkg::SizeW-sgs_pkg::LenW){1'b0}}, n});
    stat.query_stop = cur_wo && (cur_pre != cur_len);
    stat.out_free   = !out_valid || rsp.ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_side <= 1'b1;
    end else if (cfg_we) begin
      device_side <= cfg_wdata;
    end
  end

  // Chain bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      chain_count <= '0;
      total_bytes <= '0;
    end else if (cmd.clear) begin
      chain_count <= '0;
      total_bytes <= '0;
    end else if (cmd.append && !stat.full) begin
      chain_count <= chain_count + 1'b1;
      total_bytes <= total_bytes + {{(sgs_pkg::SizeW-sgs_pkg::LenW){1'b0}}, r_len};
    end
  end

  // Descriptor store
  always_ff @(posedge clk) begin
    if (cmd.append && !stat.full) begin
      entry_address[chain_count[sgs_pkg::IdxW-1:0]]  <= r_addr;
      entry_length[chain_count[sgs_pkg::IdxW-1:0]]   <= r_len;
      entry_flags[chain_count[sgs_pkg::IdxW-1:0]]    <= r_flags;
      written_prefix[chain_count[sgs_pkg::IdxW-1:0]] <= '0;
    end else if (cmd.emit == sgs_pkg::EmSeg && r_into && loc <= cur_pre) begin
      if (wr_end[sgs_pkg::LenW]) begin
        written_prefix[ix] <= '1;
      end else if (wr_end[sgs_pkg::LenW-1:0] > cur_pre) begin
        written_prefix[ix] <= wr_end[sgs_pkg::LenW-1:0];
      end
    end
  end

  // Request latch
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op      <= req.opcode;
      r_addr  <= req.desc_address;
      r_len   <= req.desc_length;
      r_flags <= req.desc_flags;
      r_size  <= req.copy_size;
      r_off   <= req.copy_offset;
      r_into  <= req.copy_into_chain;
    end
  end

  // Walk counters
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      rem  <= req.copy_size;
      done <= '0;
    end
    if (cmd.walk_reset) begin
      idx <= '0;
      cur <= '0;
      loc <= '0;
      lb  <= '0;
    end else if (cmd.seek_step) begin
      idx <= idx + 1'b1;
      cur <= cur_end[sgs_pkg::SizeW-1:0];
    end else if (cmd.seg_begin) begin
      loc <= sgs_pkg::LenW'(r_off - cur);
    end else if (cmd.query_step) begin
      idx <= idx + 1'b1;
      if (cur_wo) begin
        lb <= lb_sum[sgs_pkg::LenW] ? '1 : lb_sum[sgs_pkg::LenW-1:0];
      end
    end else if (cmd.emit == sgs_pkg::EmSeg) begin
      idx  <= idx + 1'b1;
      loc  <= '0;
      rem  <= rem - {{(sgs_pkg::SizeW-sgs_pkg::LenW){1'b0}}, n};
      done <= done + {{(sgs_pkg::SizeW-sgs_pkg::LenW){1'b0}}, n};
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit != sgs_pkg::EmNone) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Build the next result beat; unnamed fields stay zero, but last defaults to one.
  always_comb begin
    o_status_next = sgs_pkg::StOk;
    o_addr_next   = '0;
    o_len_next    = '0;
    o_idx_next    = '0;
    o_lin_next    = '0;
    o_done_next   = '0;
    o_wb_next     = '0;
    o_last_next   = 1'b1;
    unique case (cmd.emit)
      sgs_pkg::EmAppend: begin
        if (stat.full) begin
          o_status_next = sgs_pkg::StFull;
        end else begin
          o_idx_next = chain_count[sgs_pkg::IdxW-1:0];
        end
      end
      sgs_pkg::EmPlain: begin
        o_status_next = cmd.emit_status;
      end
      sgs_pkg::EmQuery: begin
        o_wb_next = lb;
      end
      sgs_pkg::EmSeg: begin
        o_addr_next = entry_address[ix] + {{(sgs_pkg::AddrW-sgs_pkg::LenW){1'b0}}, loc};
        o_len_next  = n;
        o_idx_next  = ix;
        o_lin_next  = done;
        o_done_next = done + {{(sgs_pkg::SizeW-sgs_pkg::LenW){1'b0}}, n};
        o_last_next = stat.seg_last;
      end
      sgs_pkg::EmPerm: begin
        o_status_next = sgs_pkg::StPerm;
        o_idx_next    = ix;
        o_lin_next    = done;
        o_done_next   = done;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit != sgs_pkg::EmNone) begin
      o_status <= o_status_next;
      o_addr   <= o_addr_next;
      o_len    <= o_len_next;
      o_idx    <= o_idx_next;
      o_lin    <= o_lin_next;
      o_done   <= o_done_next;
      o_wb     <= o_wb_next;
      o_last   <= o_last_next;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = o_status;
  assign rsp.seg_address   = o_addr;
  assign rsp.seg_length    = o_len;
  assign rsp.seg_index     = o_idx;
  assign rsp.linear_offset = o_lin;
  assign rsp.bytes_done    = o_done;
  assign rsp.written_bound = o_wb;
  assign rsp.last          = o_last;

endmodule

>>> hw/rtl/sgs_ctrl.sv
// ----------------------------------------------------------------------------
// sgs_ctrl
// Operation sequencer: decode, offset seek, segment walk and bound query.
// ----------------------------------------------------------------------------
module sgs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  sgs_pkg::stat_t  stat,
  output sgs_pkg::cmd_t   cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SEEK   = 3'd2;
  localparam logic [2:0] S_SEG    = 3'd3;
  localparam logic [2:0] S_QUERY  = 3'd4;
  localparam logic [2:0] S_QEMIT  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (stat.op == sgs_pkg::OpQuery) begin
          cmd.walk_reset = 1'b1;
          state_next     = S_QUERY;
        end else if (stat.op == sgs_pkg::OpCopy && !stat.size_zero && !stat.exceeds
                     && !(stat.off_zero && stat.count_zero)) begin
          cmd.walk_reset = 1'b1;
          state_next     = stat.off_zero ? S_SEG : S_SEEK;
        end else if (stat.out_free) begin
          state_next = S_IDLE;
          priority if (stat.op == sgs_pkg::OpAppend) begin
            cmd.append = 1'b1;
            cmd.emit   = sgs_pkg::EmAppend;
          end else if (stat.op == sgs_pkg::OpClear) begin
            cmd.clear = 1'b1;
            cmd.emit  = sgs_pkg::EmPlain;
          end else begin
            cmd.emit        = sgs_pkg::EmPlain;
            cmd.emit_status = stat.size_zero ? sgs_pkg::StOk
                            : stat.exceeds   ? sgs_pkg::StExceeds
                            :                  sgs_pkg::StNotFound;
          end
        end else begin
        end
      end
      S_SEEK: begin
        priority if (stat.at_end) begin
          if (stat.out_free) begin
            cmd.emit        = sgs_pkg::EmPlain;
            cmd.emit_status = sgs_pkg::StNotFound;
            state_next      = S_IDLE;
          end
        end else if (stat.seek_hit) begin
          cmd.seg_begin = 1'b1;
          state_next    = S_SEG;
        end else begin
          cmd.seek_step = 1'b1;
        end
      end
      S_SEG: begin
        if (stat.out_free) begin
          priority if (stat.at_end) begin
            cmd.emit   = sgs_pkg::EmPlain;
            state_next = S_IDLE;
          end else if (stat.perm_fail) begin
            cmd.emit   = sgs_pkg::EmPerm;
            state_next = S_IDLE;
          end else begin
            cmd.emit = sgs_pkg::EmSeg;
            if (stat.seg_last) begin
              state_next = S_IDLE;
            end
          end
        end
      end
      S_QUERY: begin
        if (stat.at_end) begin
          state_next = S_QEMIT;
        end else begin
          cmd.query_step = 1'b1;
          if (stat.query_stop) begin
            state_next = S_QEMIT;
          end
        end
      end
      S_QEMIT: begin
        if (stat.out_free) begin
          cmd.emit   = sgs_pkg::EmQuery;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hw/rtl/scatter_gather_segmenter.sv
// ----------------------------------------------------------------------------
// scatter_gather_segmenter
// Bounded scatter-gather descriptor chain with copy segmentation.
// ----------------------------------------------------------------------------
// Append and clear: the request latch and the result register lie between acceptance
//   and the beat; a query walks one descriptor a cycle.
// Copy: seek one descriptor a cycle, then one segment beat a cycle while the output
//   does not stall. One operation at a time; a new beat is taken in idle, even while
//   the last result waits downstream.
// Reset (rst, synchronous): empty the chain, set device_side to 1, drop any pending result.
// ----------------------------------------------------------------------------
module scatter_gather_segmenter (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  sgs_req_if.sink   req,
  sgs_rsp_if.source rsp
);

  sgs_pkg::cmd_t  cmd;
  sgs_pkg::stat_t stat;

  // Sequencer: owns the request handshake and issues one command per cycle.
  sgs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: store, walk state and the result register that holds each beat.
  sgs_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .req       (req),
    .rsp       (rsp)
  );

endmodule
